FILE: design/cmdu_pkg.sv
// Shared types and constants for the complex multiply / divide unit.
`timescale 1ns / 1ps

package cmdu_pkg;

  localparam int unsigned EPS_W     = 20;
  localparam logic [EPS_W-1:0] EPS_RESET = 20'd4295;
  localparam int unsigned QBITS     = 33;        // quotient bits, one per cell
  localparam int unsigned DEN_W     = 80;        // divisor scaled by 2^16
  localparam int unsigned REM_W     = 80;

  typedef enum logic {
    MODE_MUL = 1'b0,
    MODE_DIV = 1'b1
  } mode_t;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
    logic               last_in;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               saturated;
    logic               last_out;
  } out_t;

  // State that one divider cell hands to the next
  typedef struct packed {
    logic              valid;
    logic              mode;
    logic              last;
    logic              neg_re;
    logic              neg_im;
    logic              ovf_re;
    logic              ovf_im;
    logic [DEN_W-1:0]  den;
    logic [REM_W-1:0]  rem_re;
    logic [REM_W-1:0]  rem_im;
    logic [QBITS-1:0]  q_re;
    logic [QBITS-1:0]  q_im;
  } cell_t;

endpackage

FILE: design/cmdu_front.sv
// Front end: products, sign/magnitude numerators, divisor and cell-chain load.
`timescale 1ns / 1ps

module cmdu_front import cmdu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             valid,
  input  in_t              data,
  input  logic [EPS_W-1:0] epsilon,
  output cell_t            stage
);

  // stage 1: products
  logic               v1, mode1, last1;
  logic signed [63:0] p_rr, p_ii, p_ir, p_ri, s_r, s_i;
  // stage 2: numerators and divisor
  logic               v2, mode2, last2, neg_re2, neg_im2;
  logic [63:0]        mag_re2, mag_im2, den2;

  logic signed [64:0] sum_re, sum_im;
  logic [63:0]        den_sum;
  logic [48:0]        rnd_re, rnd_im;
  logic [DEN_W-1:0]   den_sh;
  cell_t              cell_next;

  // register products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= valid;
    end
    if (en) begin
      mode1 <= data.mode;
      last1 <= data.last_in;
      p_rr  <= data.a_re * data.b_re;
      p_ii  <= data.a_im * data.b_im;
      p_ir  <= data.a_im * data.b_re;
      p_ri  <= data.a_re * data.b_im;
      s_r   <= data.b_re * data.b_re;
      s_i   <= data.b_im * data.b_im;
    end
  end

  // combine products; divide uses a*conj(b)
  always_comb begin
    if (mode1 == MODE_DIV) begin
      sum_re = 65'(p_rr) + 65'(p_ii);
      sum_im = 65'(p_ir) - 65'(p_ri);
    end else begin
      sum_re = 65'(p_rr) - 65'(p_ii);
      sum_im = 65'(p_ir) + 65'(p_ri);
    end
    den_sum = 64'(s_r) + 64'(s_i) + 64'(epsilon);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      mode2   <= mode1;
      last2   <= last1;
      neg_re2 <= sum_re[64];
      neg_im2 <= sum_im[64];
      mag_re2 <= sum_re[64] ? 64'(-sum_re) : sum_re[63:0];
      mag_im2 <= sum_im[64] ? 64'(-sum_im) : sum_im[63:0];
      den2    <= den_sum;
    end
  end

  // load the cell chain: rounded product, or remainder and scaled divisor
  always_comb begin
    rnd_re = 49'(mag_re2[63:16]) + 49'(mag_re2[15]);
    rnd_im = 49'(mag_im2[63:16]) + 49'(mag_im2[15]);
    den_sh = {den2, 16'd0};
    cell_next        = '0;
    cell_next.valid  = v2;
    cell_next.mode   = mode2;
    cell_next.last   = last2;
    cell_next.neg_re = neg_re2;
    cell_next.neg_im = neg_im2;
    if (mode2 == MODE_DIV) begin
      // zero divisor: numerators are zero too, so an all-ones divisor yields zero
      cell_next.den    = (den2 == '0) ? '1 : den_sh;
      cell_next.rem_re = REM_W'(mag_re2);
      cell_next.rem_im = REM_W'(mag_im2);
      cell_next.ovf_re = (den2 != '0) && ({16'd0, mag_re2} >= den_sh);
      cell_next.ovf_im = (den2 != '0) && ({16'd0, mag_im2} >= den_sh);
    end else begin
      cell_next.q_re   = rnd_re[QBITS-1:0];
      cell_next.q_im   = rnd_im[QBITS-1:0];
      cell_next.ovf_re = |rnd_re[48:QBITS];
      cell_next.ovf_im = |rnd_im[48:QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (en) begin
      stage.valid <= cell_next.valid;
    end
    if (en) begin
      stage.mode   <= cell_next.mode;
      stage.last   <= cell_next.last;
      stage.neg_re <= cell_next.neg_re;
      stage.neg_im <= cell_next.neg_im;
      stage.ovf_re <= cell_next.ovf_re;
      stage.ovf_im <= cell_next.ovf_im;
      stage.den    <= cell_next.den;
      stage.rem_re <= cell_next.rem_re;
      stage.rem_im <= cell_next.rem_im;
      stage.q_re   <= cell_next.q_re;
      stage.q_im   <= cell_next.q_im;
    end
  end

endmodule

FILE: design/cmdu_cell.sv
// One restoring-division cell: one quotient bit for each of the two lanes.
`timescale 1ns / 1ps

module cmdu_cell import cmdu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  cell_t prev,
  output cell_t stage
);

  logic [REM_W:0] t_re, t_im, d_ext;
  logic           ge_re, ge_im;
  cell_t          cell_next;

  // shift remainder, subtract scaled divisor when it fits
  always_comb begin
    t_re  = {prev.rem_re, 1'b0};
    t_im  = {prev.rem_im, 1'b0};
    d_ext = {1'b0, prev.den};
    ge_re = (t_re >= d_ext);
    ge_im = (t_im >= d_ext);
    cell_next = prev;
    if (prev.mode == MODE_DIV) begin
      cell_next.rem_re = ge_re ? REM_W'(t_re - d_ext) : t_re[REM_W-1:0];
      cell_next.rem_im = ge_im ? REM_W'(t_im - d_ext) : t_im[REM_W-1:0];
      cell_next.q_re   = {prev.q_re[QBITS-2:0], ge_re};
      cell_next.q_im   = {prev.q_im[QBITS-2:0], ge_im};
    end
  end

  // advance to the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (en) begin
      stage.valid <= cell_next.valid;
    end
    if (en) begin
      stage.mode   <= cell_next.mode;
      stage.last   <= cell_next.last;
      stage.neg_re <= cell_next.neg_re;
      stage.neg_im <= cell_next.neg_im;
      stage.ovf_re <= cell_next.ovf_re;
      stage.ovf_im <= cell_next.ovf_im;
      stage.den    <= cell_next.den;
      stage.rem_re <= cell_next.rem_re;
      stage.rem_im <= cell_next.rem_im;
      stage.q_re   <= cell_next.q_re;
      stage.q_im   <= cell_next.q_im;
    end
  end

endmodule

FILE: design/cmdu_back.sv
// Back end: final rounding, sign, saturation and the output register.
`timescale 1ns / 1ps

module cmdu_back import cmdu_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  cell_t stage,
  output logic  valid,
  output out_t  data
);

  logic [QBITS-1:0]   qm_re, qm_im;
  logic signed [31:0] re_next, im_next;
  logic               sat_re, sat_im;

  // round the extra fraction bit of a quotient
  always_comb begin
    if (stage.mode == MODE_DIV) begin
      qm_re = (stage.q_re >> 1) + QBITS'(stage.q_re[0]);
      qm_im = (stage.q_im >> 1) + QBITS'(stage.q_im[0]);
    end else begin
      qm_re = stage.q_re;
      qm_im = stage.q_im;
    end
  end

  // apply sign and clip to the Q16.16 range
  always_comb begin
    if (stage.neg_re) begin
      sat_re  = stage.ovf_re || (qm_re > QBITS'(33'h0_8000_0000));
      re_next = sat_re ? 32'sh8000_0000 : 32'(-qm_re);
    end else begin
      sat_re  = stage.ovf_re || (qm_re > QBITS'(33'h0_7FFF_FFFF));
      re_next = sat_re ? 32'sh7FFF_FFFF : 32'(qm_re);
    end
    if (stage.neg_im) begin
      sat_im  = stage.ovf_im || (qm_im > QBITS'(33'h0_8000_0000));
      im_next = sat_im ? 32'sh8000_0000 : 32'(-qm_im);
    end else begin
      sat_im  = stage.ovf_im || (qm_im > QBITS'(33'h0_7FFF_FFFF));
      im_next = sat_im ? 32'sh7FFF_FFFF : 32'(qm_im);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= stage.valid;
    end
    if (en) begin
      data.res_re    <= re_next;
      data.res_im    <= im_next;
      data.saturated <= sat_re || sat_im;
      data.last_out  <= stage.last;
    end
  end

endmodule

FILE: design/complex_multiply_divide_unit_top.sv
// Top level of the complex multiply / regularized complex divide unit.
`timescale 1ns / 1ps

// Takes one beat per cycle while not stalled and returns one result beat per
// input beat, in order, after three front stages (products, numerators and
// divisor, chain load), a row of 33 division cells that each settle one
// quotient bit per lane, and the output register, which also rounds and
// clips. Multiply beats travel the same row untouched. The whole pipe holds
// while the output register is full and stalled, so in_stall follows
// out_stall in that case.
// epsilon may be written only while no beat is in flight.

module complex_multiply_divide_unit_top import cmdu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_t             out_data,
  input  logic             epsilon_we,
  input  logic [EPS_W-1:0] epsilon_wdata
);

  logic             en;
  logic [EPS_W-1:0] epsilon;
  cell_t            chain [QBITS+1];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // hold the regularizer
  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EPS_RESET;
    end else if (epsilon_we) begin
      epsilon <= epsilon_wdata;
    end
  end

  cmdu_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .valid   (in_valid),
    .data    (in_data),
    .epsilon (epsilon),
    .stage   (chain[0])
  );

  for (genvar i = 0; i < QBITS; i++) begin : g_cell
    cmdu_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .prev  (chain[i]),
      .stage (chain[i+1])
    );
  end

  cmdu_back u_back (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .stage (chain[QBITS]),
    .valid (out_valid),
    .data  (out_data)
  );

endmodule

FILE: design/cmdu_checker.sv
// Port-level checks for the complex multiply / divide unit.
`timescale 1ns / 1ps

module cmdu_checker import cmdu_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // a held result beat stays
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // a stalled output backs up the input
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output held");

  // reset empties the pipe
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat right after reset");

  // a clip flag needs a part at a limit
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.saturated |->
      out_data.res_re == 32'sh7FFF_FFFF || out_data.res_re == 32'sh8000_0000 ||
      out_data.res_im == 32'sh7FFF_FFFF || out_data.res_im == 32'sh8000_0000)
    else $error("saturated set without a clipped part");

endmodule

bind complex_multiply_divide_unit_top cmdu_checker u_cmdu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
